>>> rtl/vgsc_pkg.sv
// package for the voxel grid shape carver
// types, opcodes and sizing constants; no dependencies
package vgsc_pkg;

  localparam int unsigned GridXDef = 32;
  localparam int unsigned GridYDef = 32;
  localparam int unsigned GridZDef = 32;
  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned CfgDataW = 8;

  typedef enum logic [3:0] {
    OP_SET_VOXEL   = 4'd0,
    OP_CLR_VOXEL   = 4'd1,
    OP_SET_BOX     = 4'd2,
    OP_CLR_BOX     = 4'd3,
    OP_SET_SPHERE  = 4'd4,
    OP_CLR_SPHERE  = 4'd5,
    OP_SET_ELLIPSE = 4'd6,
    OP_CLR_ELLIPSE = 4'd7,
    OP_READ_VOXEL  = 4'd8
  } opcode_e;

  typedef enum logic [1:0] {
    REG_PAINT_RED   = 2'd0,
    REG_PAINT_GREEN = 2'd1,
    REG_PAINT_BLUE  = 2'd2,
    REG_PAINT_ALPHA = 2'd3
  } cfg_reg_e;

  typedef struct packed {
    logic [3:0] opcode;
    logic [4:0] pos_x;
    logic [4:0] pos_y;
    logic [4:0] pos_z;
    logic [4:0] end_x;
    logic [4:0] end_y;
    logic [4:0] end_z;
    logic [5:0] ball_radius;
    logic [5:0] semi_axis_x;
    logic [5:0] semi_axis_y;
    logic [5:0] semi_axis_z;
  } cmd_t;

  typedef struct packed {
    logic       voxel_on;
    logic [7:0] voxel_red;
    logic [7:0] voxel_green;
    logic [7:0] voxel_blue;
    logic [7:0] voxel_alpha;
  } rsp_t;

endpackage

>>> rtl/vgsc_ram.sv
// generic simple dual port ram (one write port, one read port) with registered read
// no dependencies
module vgsc_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end
endmodule

>>> rtl/voxel_grid_shape_carver_core.sv
// voxel grid shape carver, top level
// uses vgsc_pkg and vgsc_ram
//
// a transaction is taken when start is high and busy is low; every command
// gives exactly one result, shown for one cycle with done_o high (no stall).
// after reset the block first runs a clearing pass that zeroes each of the
// GRID_X*GRID_Y*GRID_Z grid voxels (32768 by default), busy throughout.
// single voxel commands and reads pass through the read state: ram write or
// read, result capture, strobe. box, sphere and ellipsoid commands sweep every
// grid voxel, one voxel tested per cycle through a three stage pipe on the single
// write and read port pair, writing each hit. the result follows a setup state,
// the sweep, a drain state that empties the pipe, then the strobe.
// the ellipsoid test is multiplied out and computed over pipeline stages, one
// multiplier layer per stage. paint registers may be written whenever the
// block is idle.
module voxel_grid_shape_carver_core #(
  parameter int unsigned GRID_X = vgsc_pkg::GridXDef,
  parameter int unsigned GRID_Y = vgsc_pkg::GridYDef,
  parameter int unsigned GRID_Z = vgsc_pkg::GridZDef
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start,
  output logic                          busy,
  input  vgsc_pkg::cmd_t                cmd_i,
  output logic                          done_o,
  output vgsc_pkg::rsp_t                rsp_o,
  input  logic                          cfg_we_i,
  input  logic [vgsc_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [vgsc_pkg::CfgDataW-1:0] cfg_data_i
);
  import vgsc_pkg::*;

  localparam int unsigned XW    = (GRID_X > 1) ? $clog2(GRID_X) : 1;
  localparam int unsigned YW    = (GRID_Y > 1) ? $clog2(GRID_Y) : 1;
  localparam int unsigned ZW    = (GRID_Z > 1) ? $clog2(GRID_Z) : 1;
  localparam int unsigned AW    = XW + YW + ZW;
  // the ram spans the whole packed coordinate space
  localparam int unsigned Depth = 1 << AW;
  localparam int unsigned MaxW  = (XW > YW) ? ((XW > ZW) ? XW : ZW) :
                                              ((YW > ZW) ? YW : ZW);
  // coordinates are handled one bit wider than both field and grid
  localparam int unsigned CW    = ((MaxW > 5) ? MaxW : 5) + 1;
  localparam int unsigned SW    = 2 * CW;
  localparam int unsigned SSW   = SW + 2;
  localparam int unsigned EW    = SW + 24;
  localparam int unsigned ESW   = EW + 2;

  typedef enum logic [4:0] {
    ST_CLEAR = 5'b00001,
    ST_IDLE  = 5'b00010,
    ST_SWEEP = 5'b00100,
    ST_DRAIN = 5'b01000,
    ST_READ  = 5'b10000
  } state_e;

  state_e state_q, state_d;
  cmd_t   cmd_q;
  logic [7:0] red_q, green_q, blue_q, alpha_q;

  // sweep counters
  logic [XW-1:0] ix_q;
  logic [YW-1:0] iy_q;
  logic [ZW-1:0] iz_q;
  logic          last_cnt;
  logic [2:0]    drain_q;

  // ram
  logic          we;
  logic [AW-1:0] waddr, raddr;
  logic [32:0]   wdata, rdata;

  vgsc_ram #(.Width(33), .Depth(Depth)) u_ram (
    .clk_i  (clk_i),
    .we_i   (we),
    .waddr_i(waddr),
    .wdata_i(wdata),
    .raddr_i(raddr),
    .rdata_o(rdata)
  );

  function automatic logic [SW-1:0] sqd(input logic [CW-1:0] a, input logic [CW-1:0] b);
    logic [CW-1:0] d;
    d = (a > b) ? a - b : b - a;
    return SW'(d) * SW'(d);
  endfunction

  logic cnt_end_x, cnt_end_y, cnt_end_z;
  assign cnt_end_z = (32'(iz_q) == GRID_Z - 1);
  assign cnt_end_y = (32'(iy_q) == GRID_Y - 1);
  assign cnt_end_x = (32'(ix_q) == GRID_X - 1);
  assign last_cnt  = cnt_end_x && cnt_end_y && cnt_end_z;

  // sweep pipe: s1 squares, s2 box and sphere decision, s3 ellipsoid products, then decision and write
  logic          s1_v_q;
  logic [AW-1:0] s1_a_q;
  logic [SW-1:0] s1_dx_q, s1_dy_q, s1_dz_q;
  logic          s1_box_q;
  logic          s2_v_q;
  logic [AW-1:0] s2_a_q;
  logic          s2_in_q;
  logic [SW-1:0] p_dx_q, p_dy_q, p_dz_q;
  logic [11:0]   a2_q, b2_q, c2_q;
  logic [23:0]   bc_q, ac_q, ab_q;
  logic [35:0]   abc_q;
  logic [13:0]   sph_q;
  logic          s3_v_q;
  logic [AW-1:0] s3_a_q;
  logic [EW-1:0] tx_q, ty_q, tz_q;
  logic [35:0]   abc3_q;
  logic          s3_in_q;

  opcode_e op;
  assign op = opcode_e'(cmd_q.opcode);
  logic is_set, is_box, is_sph, is_ell;
  always_comb begin
    is_box = 1'b0; is_sph = 1'b0; is_ell = 1'b0; is_set = 1'b0;
    case (op)
      OP_SET_BOX, OP_CLR_BOX:         is_box = 1'b1;
      OP_SET_SPHERE, OP_CLR_SPHERE:   is_sph = 1'b1;
      OP_SET_ELLIPSE, OP_CLR_ELLIPSE: is_ell = 1'b1;
      default: ;
    endcase
    case (op)
      OP_SET_VOXEL, OP_SET_BOX, OP_SET_SPHERE, OP_SET_ELLIPSE: is_set = 1'b1;
      default: ;
    endcase
  end

  logic [CW-1:0] cx, cy, cz, ix_w, iy_w, iz_w;
  assign cx = CW'(cmd_q.pos_x);
  assign cy = CW'(cmd_q.pos_y);
  assign cz = CW'(cmd_q.pos_z);
  assign ix_w = CW'(ix_q);
  assign iy_w = CW'(iy_q);
  assign iz_w = CW'(iz_q);

  logic box_hit;
  assign box_hit = (ix_w >= cx) && (ix_w <= CW'(cmd_q.end_x)) &&
                   (iy_w >= cy) && (iy_w <= CW'(cmd_q.end_y)) &&
                   (iz_w >= cz) && (iz_w <= CW'(cmd_q.end_z));

  logic sweep_issue;
  assign sweep_issue = (state_q == ST_SWEEP);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q <= 1'b0;
      s2_v_q <= 1'b0;
      s3_v_q <= 1'b0;
    end else begin
      s1_v_q <= sweep_issue;
      s2_v_q <= s1_v_q;
      s3_v_q <= s2_v_q;
    end
  end

  // payload pipe
  always_ff @(posedge clk_i) begin
    s1_a_q   <= {ix_q, iy_q, iz_q};
    s1_dx_q  <= sqd(ix_w, cx);
    s1_dy_q  <= sqd(iy_w, cy);
    s1_dz_q  <= sqd(iz_w, cz);
    s1_box_q <= box_hit;
    a2_q     <= 12'(cmd_q.semi_axis_x * cmd_q.semi_axis_x);
    b2_q     <= 12'(cmd_q.semi_axis_y * cmd_q.semi_axis_y);
    c2_q     <= 12'(cmd_q.semi_axis_z * cmd_q.semi_axis_z);
    bc_q     <= b2_q * c2_q;
    ac_q     <= a2_q * c2_q;
    ab_q     <= a2_q * b2_q;
    abc_q    <= 36'(ab_q * c2_q);
    sph_q    <= 14'(cmd_q.ball_radius * cmd_q.ball_radius);
    s2_a_q   <= s1_a_q;
    p_dx_q   <= s1_dx_q;
    p_dy_q   <= s1_dy_q;
    p_dz_q   <= s1_dz_q;
    s2_in_q  <= is_box ? s1_box_q :
                (SSW'(s1_dx_q) + SSW'(s1_dy_q) + SSW'(s1_dz_q) <= SSW'(sph_q));
    s3_a_q   <= s2_a_q;
    tx_q     <= EW'(p_dx_q * bc_q);
    ty_q     <= EW'(p_dy_q * ac_q);
    tz_q     <= EW'(p_dz_q * ab_q);
    abc3_q   <= abc_q;
    s3_in_q  <= s2_in_q;
  end

  logic ell_zero;
  assign ell_zero = (cmd_q.semi_axis_x == '0) || (cmd_q.semi_axis_y == '0) ||
                    (cmd_q.semi_axis_z == '0);
  logic s3_hit;
  assign s3_hit = is_ell ? (!ell_zero && (ESW'(tx_q) + ESW'(ty_q) + ESW'(tz_q) <=
                                          ESW'(abc3_q)))
                         : s3_in_q;

  // ---- single voxel path
  logic inb;
  assign inb = (32'(cmd_q.pos_x) < GRID_X) && (32'(cmd_q.pos_y) < GRID_Y) &&
               (32'(cmd_q.pos_z) < GRID_Z);
  logic [AW-1:0] vaddr;
  assign vaddr = {XW'(cmd_q.pos_x), YW'(cmd_q.pos_y), ZW'(cmd_q.pos_z)};
  logic [31:0] paint;
  assign paint = {red_q, green_q, blue_q, alpha_q};

  always_comb begin
    we    = 1'b0;
    waddr = s3_a_q;
    wdata = {is_set, paint};
    raddr = vaddr;
    if (state_q == ST_CLEAR) begin
      we    = 1'b1;
      waddr = {ix_q, iy_q, iz_q};
      wdata = '0;
    end else if (s3_v_q && s3_hit) begin
      we = 1'b1;
    end else if (state_q == ST_READ && drain_q == 3'd0 && inb &&
                 (op == OP_SET_VOXEL || op == OP_CLR_VOXEL)) begin
      we    = 1'b1;
      waddr = vaddr;
    end
  end

  // ---- control
  logic [2:0] drain_d;
  logic done_d;
  always_comb begin
    state_d = state_q;
    drain_d = drain_q;
    done_d  = 1'b0;
    unique case (state_q)
      ST_CLEAR: if (last_cnt) state_d = ST_IDLE;
      ST_IDLE: if (start) begin
        state_d = ST_READ;
        drain_d = '0;
      end
      ST_READ: begin
        drain_d = drain_q + 3'd1;
        if (drain_q == 3'd0 && (is_box || is_sph || is_ell)) begin
          state_d = ST_SWEEP;
        end else if (drain_q == 3'd2) begin
          state_d = ST_IDLE;
          done_d  = 1'b1;
        end
      end
      ST_SWEEP: if (last_cnt) begin
        state_d = ST_DRAIN;
        drain_d = '0;
      end
      ST_DRAIN: begin
        drain_d = drain_q + 3'd1;
        if (drain_q == 3'd3) begin
          state_d = ST_IDLE;
          done_d  = 1'b1;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  logic rd_ok;
  assign rd_ok = (op == OP_READ_VOXEL) && inb && rdata[32];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
      drain_q <= '0;
      done_o  <= 1'b0;
      ix_q    <= '0;
      iy_q    <= '0;
      iz_q    <= '0;
      red_q   <= '0;
      green_q <= '0;
      blue_q  <= '0;
      alpha_q <= '0;
    end else begin
      state_q <= state_d;
      drain_q <= drain_d;
      done_o  <= done_d;
      if (state_q == ST_CLEAR || state_q == ST_SWEEP) begin
        if (cnt_end_z) begin
          iz_q <= '0;
          if (cnt_end_y) begin
            iy_q <= '0;
            ix_q <= cnt_end_x ? '0 : ix_q + XW'(1);
          end else begin
            iy_q <= iy_q + YW'(1);
          end
        end else begin
          iz_q <= iz_q + ZW'(1);
        end
      end
      if (cfg_we_i) begin
        unique case (cfg_reg_e'(cfg_idx_i))
          REG_PAINT_RED:   red_q   <= cfg_data_i;
          REG_PAINT_GREEN: green_q <= cfg_data_i;
          REG_PAINT_BLUE:  blue_q  <= cfg_data_i;
          REG_PAINT_ALPHA: alpha_q <= cfg_data_i;
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == ST_IDLE && start) cmd_q <= cmd_i;
    if (state_q == ST_READ && drain_q == 3'd1) begin
      rsp_o <= rd_ok ? {1'b1, rdata[31:0]} : '0;
    end else if (done_d) begin
      rsp_o <= (state_q == ST_READ) ? rsp_o : '0;
    end
  end

  assign busy = (state_q != ST_IDLE);
endmodule

>>> rtl/vgsc_checker.sv
// port level checker for the voxel grid shape carver
// uses vgsc_pkg; bound to voxel_grid_shape_carver_core
module vgsc_checker (
  input logic           clk_i,
  input logic           rst_ni,
  input logic           start,
  input logic           busy,
  input logic           done_o,
  input vgsc_pkg::rsp_t rsp_o
);
  import vgsc_pkg::*;

  // a taken transaction makes the block busy next cycle
  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy |=> busy) else $error("busy not raised after accept");

  // a result ends the transaction
  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !busy) else $error("busy while result shown");

  // strobe lasts one cycle
  a_done_pulse: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !done_o) else $error("result strobe longer than a cycle");

  // an off voxel carries no colour
  a_off_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && !rsp_o.voxel_on |-> rsp_o == '0) else $error("colour on off voxel");
endmodule

bind voxel_grid_shape_carver_core vgsc_checker u_vgsc_checker (
  .clk_i (clk_i),
  .rst_ni(rst_ni),
  .start (start),
  .busy  (busy),
  .done_o(done_o),
  .rsp_o (rsp_o)
);
